FILE: rtl/dse_pkg.sv
package dse_pkg;

  localparam int DEF_MAX_REF_LENGTH   = 256;
  localparam int DEF_MAX_QUERY_LENGTH = 65535;
  localparam int DEF_SAMPLE_WIDTH     = 16;

  localparam int DIST_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int QUOT_W    = DIST_W + FRAC_BITS;
  localparam int STEP_W    = $clog2(QUOT_W);
  localparam int HUND_W    = 15;

  localparam logic [DIST_W-1:0] DIST_INF    = '1;
  localparam logic [31:0]       SIM_MIN     = 32'h8000_0000;
  localparam logic [QUOT_W-1:0] ONE_Q16     = QUOT_W'(65536);
  // 65536 - q drops below INT32_MIN beyond this quotient
  localparam logic [QUOT_W-1:0] SIM_SAT_LIM = QUOT_W'(64'h0000_0000_8001_0000);
  localparam logic [HUND_W-1:0] HUNDRED_Q88 = HUND_W'(25600);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_FIN,
    ST_DIVGO,
    ST_DIVWAIT,
    ST_OUT
  } state_t;

  typedef enum logic {
    OP_LOAD_REF = 1'b0,
    OP_QUERY    = 1'b1
  } opcode_t;

  typedef struct packed {
    logic accept_load;
    logic accept_query;
    logic row_end;
    logic fin;
    logic div_start;
    logic emit;
  } dse_cmd_t;

  typedef struct packed {
    logic row_busy;
    logic last_item;
    logic special;
    logic div_done;
  } dse_stat_t;

endpackage

FILE: rtl/dtw_similarity_engine.sv
// Reference load: one cycle per sample, busy stays low.
// Query sample: busy while its row is computed, one cell per cycle through the row memory
// with one read stage in front; the stored reference length sets the row length.
// Final query sample: busy further through the bit-serial divider, which is skipped when the
// reference is empty or the distance saturates; done pulses once, receiver cannot stall.
// Synchronous reset: empty reference, query count zero, idle.
module dtw_similarity_engine #(
  parameter int MAX_REF_LENGTH   = dse_pkg::DEF_MAX_REF_LENGTH,
  parameter int MAX_QUERY_LENGTH = dse_pkg::DEF_MAX_QUERY_LENGTH,
  parameter int SAMPLE_WIDTH     = dse_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           opcode,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           last,
  output logic                           done,
  output logic [31:0]                    distance,
  output logic signed [31:0]             similarity,
  output logic                           empty_reference
);

  dse_pkg::dse_cmd_t  cmd;
  dse_pkg::dse_stat_t stat;

  dse_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .opcode(opcode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  dse_datapath #(
    .MAX_REF_LENGTH  (MAX_REF_LENGTH),
    .MAX_QUERY_LENGTH(MAX_QUERY_LENGTH),
    .SAMPLE_WIDTH    (SAMPLE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sample         (sample),
    .last           (last),
    .stat           (stat),
    .distance       (distance),
    .similarity     (similarity),
    .empty_reference(empty_reference)
  );

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe outside an active transaction");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode) |=> busy)
    else $error("query sample did not start a row");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !opcode) |=> !busy)
    else $error("reference load left the engine busy");

  a_empty_res: assert property (@(posedge clk) disable iff (rst)
    (done && empty_reference) |-> (distance == 32'hFFFF_FFFF && similarity == 32'sh8000_0000))
    else $error("empty reference result malformed");

endmodule

FILE: rtl/dse_divider.sv
module dse_divider #(
  parameter int DEN_W = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [dse_pkg::QUOT_W-1:0] dividend,
  input  logic [DEN_W-1:0]           divisor,
  output logic                       done,
  output logic [dse_pkg::QUOT_W-1:0] quotient
);

  logic                         run;
  logic [dse_pkg::STEP_W-1:0]   cnt;
  logic [DEN_W-1:0]             rem;
  logic [dse_pkg::QUOT_W-1:0]   quo;
  logic [DEN_W:0]               rem_sh;
  logic [DEN_W+1:0]             diff;
  logic                         ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem, quo[dse_pkg::QUOT_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, divisor};
    ge     = ~diff[DEN_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == dse_pkg::STEP_W'(dse_pkg::QUOT_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (run) begin
      rem <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo <= {quo[dse_pkg::QUOT_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

FILE: rtl/dse_ctrl.sv
module dse_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               opcode,
  input  dse_pkg::dse_stat_t stat,
  output dse_pkg::dse_cmd_t  cmd,
  output logic               busy,
  output logic               done
);

  dse_pkg::state_t state, state_next;
  logic            accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dse_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    accept     = start && (state == dse_pkg::ST_IDLE);
    unique case (state)
      dse_pkg::ST_IDLE: begin
        if (accept) begin
          if (opcode == dse_pkg::OP_QUERY) begin
            cmd.accept_query = 1'b1;
            state_next       = dse_pkg::ST_ROW;
          end else begin
            cmd.accept_load = 1'b1;
          end
        end
      end
      dse_pkg::ST_ROW: begin
        if (!stat.row_busy) begin
          cmd.row_end = 1'b1;
          state_next  = stat.last_item ? dse_pkg::ST_FIN : dse_pkg::ST_IDLE;
        end
      end
      dse_pkg::ST_FIN: begin
        cmd.fin    = 1'b1;
        state_next = stat.special ? dse_pkg::ST_OUT : dse_pkg::ST_DIVGO;
      end
      dse_pkg::ST_DIVGO: begin
        cmd.div_start = 1'b1;
        state_next    = dse_pkg::ST_DIVWAIT;
      end
      dse_pkg::ST_DIVWAIT: begin
        if (stat.div_done) begin
          state_next = dse_pkg::ST_OUT;
        end
      end
      dse_pkg::ST_OUT: begin
        cmd.emit   = 1'b1;
        state_next = dse_pkg::ST_IDLE;
      end
      default: begin
        state_next = dse_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state != dse_pkg::ST_IDLE);
  assign done = cmd.emit;

endmodule

FILE: rtl/dse_datapath.sv
module dse_datapath #(
  parameter int MAX_REF_LENGTH   = dse_pkg::DEF_MAX_REF_LENGTH,
  parameter int MAX_QUERY_LENGTH = dse_pkg::DEF_MAX_QUERY_LENGTH,
  parameter int SAMPLE_WIDTH     = dse_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  dse_pkg::dse_cmd_t              cmd,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           last,
  output dse_pkg::dse_stat_t             stat,
  output logic [31:0]                    distance,
  output logic signed [31:0]             similarity,
  output logic                           empty_reference
);

  localparam int IDX_W = (MAX_REF_LENGTH > 1) ? $clog2(MAX_REF_LENGTH) : 1;
  localparam int CNT_W = $clog2(MAX_REF_LENGTH + 1);
  localparam int QC_W  = $clog2(MAX_QUERY_LENGTH + 1);
  localparam int LEN_W = (QC_W > CNT_W) ? QC_W : CNT_W;
  localparam int DEN_W = LEN_W + dse_pkg::HUND_W;
  localparam int SW    = SAMPLE_WIDTH;
  localparam int DW    = dse_pkg::DIST_W;

  logic [SW-1:0] ref_mem [MAX_REF_LENGTH];
  logic [DW-1:0] row_mem [MAX_REF_LENGTH];

  logic [CNT_W-1:0] ref_cnt;
  logic [QC_W-1:0]  qry_cnt;
  logic             loading;

  logic [SW-1:0]    sample_q;
  logic             last_q;
  logic             first_row;
  logic             issue;
  logic [CNT_W-1:0] rd_idx;
  logic             stg_vld;
  logic [IDX_W-1:0] stg_idx;
  logic [SW-1:0]    ref_q;
  logic [DW-1:0]    up_q;
  logic [DW-1:0]    left;
  logic [DW-1:0]    diag;

  logic [CNT_W-1:0] wr_base;
  logic [SW:0]      sd;
  logic [SW:0]      mag;
  logic [DW-1:0]    up;
  logic [DW-1:0]    mn;
  logic [DW:0]      sum;
  logic [DW-1:0]    cell_cost;

  logic [LEN_W-1:0]             len;
  logic [DEN_W-1:0]             den;
  logic                         div_done;
  logic [dse_pkg::QUOT_W-1:0]   quot;

  assign wr_base = loading ? ref_cnt : '0;

  // reference store
  always_ff @(posedge clk) begin
    if (cmd.accept_load && (wr_base < CNT_W'(MAX_REF_LENGTH))) begin
      ref_mem[wr_base[IDX_W-1:0]] <= sample;
    end
    ref_q <= ref_mem[rd_idx[IDX_W-1:0]];
  end

  // previous row; the first row of a query ignores it
  always_ff @(posedge clk) begin
    if (stg_vld) begin
      row_mem[stg_idx] <= cell_cost;
    end
    up_q <= row_mem[rd_idx[IDX_W-1:0]];
  end

  always_comb begin
    sd   = {sample_q[SW-1], sample_q} - {ref_q[SW-1], ref_q};
    mag  = sd[SW] ? (~sd + 1'b1) : sd;
    up   = first_row ? dse_pkg::DIST_INF : up_q;
    mn   = (up < left) ? up : left;
    mn   = (mn < diag) ? mn : diag;
    sum  = {1'b0, mn} + (DW + 1)'(mag[SW-1:0]);
    cell_cost = (sum >= {1'b0, dse_pkg::DIST_INF}) ? dse_pkg::DIST_INF : sum[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_cnt <= '0;
      qry_cnt <= '0;
      loading <= 1'b0;
      issue   <= 1'b0;
      stg_vld <= 1'b0;
    end else begin
      stg_vld <= issue;
      if (issue) begin
        rd_idx <= rd_idx + 1'b1;
        issue  <= ((rd_idx + 1'b1) != ref_cnt);
      end
      if (cmd.accept_load) begin
        if (!loading) begin
          qry_cnt <= '0;
        end
        if (wr_base < CNT_W'(MAX_REF_LENGTH)) begin
          ref_cnt <= wr_base + 1'b1;
        end else begin
          ref_cnt <= wr_base;
        end
        loading <= !last;
      end
      if (cmd.accept_query) begin
        loading <= 1'b0;
        rd_idx  <= '0;
        issue   <= (ref_cnt != '0);
      end
      if (cmd.row_end && (qry_cnt != QC_W'(MAX_QUERY_LENGTH))) begin
        qry_cnt <= qry_cnt + 1'b1;
      end
      if (cmd.emit) begin
        qry_cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_query) begin
      sample_q  <= sample;
      last_q    <= last;
      first_row <= (qry_cnt == '0);
      left      <= dse_pkg::DIST_INF;
      diag      <= (qry_cnt == '0) ? '0 : dse_pkg::DIST_INF;
    end else if (stg_vld) begin
      left    <= cell_cost;
      diag    <= up;
    end
    if (issue) begin
      stg_idx <= rd_idx[IDX_W-1:0];
    end
  end

  assign len = (LEN_W'(qry_cnt) > LEN_W'(ref_cnt)) ? LEN_W'(qry_cnt) : LEN_W'(ref_cnt);

  // result registers; left holds the last cell of the final row
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      den             <= DEN_W'(len) * DEN_W'(dse_pkg::HUNDRED_Q88);
      empty_reference <= (ref_cnt == '0);
      distance        <= (ref_cnt == '0) ? dse_pkg::DIST_INF : left;
      similarity      <= dse_pkg::SIM_MIN;
    end else if (div_done) begin
      similarity <= (quot > dse_pkg::SIM_SAT_LIM) ? dse_pkg::SIM_MIN
                                                  : 32'(dse_pkg::ONE_Q16 - quot);
    end
  end

  dse_divider #(
    .DEN_W(DEN_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend({distance, dse_pkg::FRAC_BITS'(0)}),
    .divisor (den),
    .done    (div_done),
    .quotient(quot)
  );

  assign stat.row_busy  = issue | stg_vld;
  assign stat.last_item = last_q;
  assign stat.special   = (ref_cnt == '0) || (left == dse_pkg::DIST_INF);
  assign stat.div_done  = div_done;

endmodule
